FILE: src/heading_pid_with_settle_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heading PID controller
// Clocked, reset-qualified property macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef HEADING_PID_WITH_SETTLE_MACROS_SVH
`define HEADING_PID_WITH_SETTLE_MACROS_SVH

// Same-cycle implication
`define HPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Types and constants shared by the heading PID controller modules.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam logic signed [17:0] FULL_TURN      = 18'sd36000;
  localparam logic signed [17:0] HALF_TURN      = 18'sd18000;
  localparam logic        [26:0] INTEGRAL_LIMIT = 27'd6000;
  localparam logic signed [15:0] INTEGRAL_GATE  = 16'sd500;
  localparam logic signed [14:0] DRIVE_LIMIT    = 15'sd12000;
  localparam logic        [27:0] SAT_LEVEL      = 28'd60005;
  localparam logic signed [17:0] RECIP5         = 18'sd52429;
  localparam logic        [34:0] ROUND_BIAS     = 35'd320;
  localparam logic        [34:0] ROUND_BIAS_NEG = 35'd321;

  localparam logic [2:0] REG_TARGET       = 3'd0;
  localparam logic [2:0] REG_GAIN_P       = 3'd1;
  localparam logic [2:0] REG_GAIN_I       = 3'd2;
  localparam logic [2:0] REG_GAIN_D       = 3'd3;
  localparam logic [2:0] REG_SETTLE_ERROR = 3'd4;
  localparam logic [2:0] REG_SETTLE_SPEED = 3'd5;
  localparam logic [2:0] REG_SETTLE_RATE  = 3'd6;
  localparam logic [2:0] REG_TIMEOUT      = 3'd7;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [2:0] {
    MUL_E_TICK,
    MUL_P_E,
    MUL_D_D,
    MUL_I_INT,
    MUL_RECIP
  } mul_sel_e;

  typedef struct packed {
    logic [15:0] target_heading;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [14:0] settle_error;
    logic [10:0] settle_speed;
    logic [14:0] settle_rate;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     load_err;
    logic     eval;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     integ_ld;
    logic     acc_load;
    logic     acc_add;
    logic     acc_add_gated;
    logic     tri_ld;
    logic     mag_ld;
    logic     sat_ld;
    logic     finish;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic pid_tick;
  } status_t;

endpackage

FILE: src/hps_cfg.sv
// ----------------------------------------------------------------------------
// hps_cfg
// Configuration register file with reset defaults and width masking.
// ----------------------------------------------------------------------------
module hps_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [2:0]          addr_i,
  input  logic [15:0]         wdata_i,
  output hps_pkg::cfg_t       cfg_o
);
  import hps_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_heading <= 16'd0;
      cfg_q.gain_p         <= 16'd1024;
      cfg_q.gain_i         <= 16'd230;
      cfg_q.gain_d         <= 16'd6127;
      cfg_q.settle_error   <= 15'd150;
      cfg_q.settle_speed   <= 11'd0;
      cfg_q.settle_rate    <= 15'd0;
      cfg_q.timeout_ms     <= 16'hFFFF;
    end else if (we_i) begin
      unique case (addr_i)
        REG_TARGET:       cfg_q.target_heading <= wdata_i;
        REG_GAIN_P:       cfg_q.gain_p         <= wdata_i;
        REG_GAIN_I:       cfg_q.gain_i         <= wdata_i;
        REG_GAIN_D:       cfg_q.gain_d         <= wdata_i;
        REG_SETTLE_ERROR: cfg_q.settle_error   <= wdata_i[14:0];
        REG_SETTLE_SPEED: cfg_q.settle_speed   <= wdata_i[10:0];
        REG_SETTLE_RATE:  cfg_q.settle_rate    <= wdata_i[14:0];
        REG_TIMEOUT:      cfg_q.timeout_ms     <= wdata_i;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/hps_ctrl.sv
// ----------------------------------------------------------------------------
// hps_ctrl
// Sequencer for one item: wrap, settle test, shared-multiplier PID passes,
// then hand-off to the output register.
// ----------------------------------------------------------------------------
module hps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  hps_pkg::status_t status_i,
  output hps_pkg::cmd_t    cmd_o
);
  import hps_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WRAP = 4'd1;
  localparam logic [3:0] S_TEST = 4'd2;
  localparam logic [3:0] S_P1   = 4'd3;
  localparam logic [3:0] S_P2   = 4'd4;
  localparam logic [3:0] S_P3   = 4'd5;
  localparam logic [3:0] S_P4   = 4'd6;
  localparam logic [3:0] S_P5   = 4'd7;
  localparam logic [3:0] S_P6   = 4'd8;
  localparam logic [3:0] S_P7   = 4'd9;
  localparam logic [3:0] S_P8   = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  cmd_t       cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd.load_err = 1'b1;
        state_d      = S_TEST;
      end
      S_TEST: begin
        cmd.eval    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_E_TICK;
        state_d     = status_i.pid_tick ? S_P1 : S_DONE;
      end
      S_P1: begin
        cmd.integ_ld = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_P_E;
        state_d      = S_P2;
      end
      S_P2: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_D_D;
        state_d      = S_P3;
      end
      S_P3: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_I_INT;
        state_d     = S_P4;
      end
      S_P4: begin
        cmd.acc_add_gated = 1'b1;
        state_d           = S_P5;
      end
      S_P5: begin
        cmd.tri_ld = 1'b1;
        state_d    = S_P6;
      end
      S_P6: begin
        cmd.mag_ld = 1'b1;
        state_d    = S_P7;
      end
      S_P7: begin
        cmd.sat_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RECIP;
        state_d     = S_P8;
      end
      S_P8: begin
        cmd.finish = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

FILE: src/hps_datapath.sv
// ----------------------------------------------------------------------------
// hps_datapath
// Angle wrap, settle test, loop state, shared 18x18 multiplier, accumulator,
// rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module hps_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hps_pkg::cfg_t       cfg_i,
  input  hps_pkg::cmd_t       cmd_i,
  output hps_pkg::status_t    status_o,
  input  logic                operation_i,
  input  logic [15:0]         heading_i,
  input  logic [9:0]          tick_ms_i,
  input  logic signed [11:0]  wheel_speed_i,
  input  logic signed [15:0]  turn_rate_i,
  output logic [55:0]         result_o
);
  import hps_pkg::*;

  // Captured item
  logic               op_q;
  logic [15:0]        heading_q;
  logic [9:0]         tick_q;
  logic signed [11:0] speed_q;
  logic signed [15:0] rate_q;

  // Loop state
  logic               enabled_q;
  logic [15:0]        elapsed_q;
  logic signed [13:0] integral_q;
  logic signed [15:0] prev_q;

  // Work registers
  logic signed [15:0] e_q;
  logic signed [33:0] prod_q;
  logic signed [13:0] integ_q;
  logic signed [33:0] acc_q;
  logic signed [34:0] n_q;
  logic [34:0]        mag_q;
  logic               neg_q;
  logic               sat_q;
  logic signed [14:0] res_drive_q;
  logic               res_settled_q;
  logic               res_sat_q;

  // Output register
  logic signed [14:0] out_left_q;
  logic signed [14:0] out_right_q;
  logic signed [15:0] out_err_q;
  logic               out_settled_q;
  logic               out_running_q;
  logic               out_sat_q;

  // Wrap target minus heading into (-18000, 18000]
  logic signed [17:0] diff, red, wrap_v;
  always_comb begin
    diff = $signed({2'b00, cfg_i.target_heading}) - $signed({2'b00, heading_q});
    if (diff >= FULL_TURN) begin
      red = diff - FULL_TURN;
    end else if (diff <= -FULL_TURN) begin
      red = diff + FULL_TURN;
    end else begin
      red = diff;
    end
    if (red > HALF_TURN) begin
      wrap_v = red - FULL_TURN;
    end else if (red <= -HALF_TURN) begin
      wrap_v = red + FULL_TURN;
    end else begin
      wrap_v = red;
    end
  end

  // Settle test
  logic [15:0] mag_e;
  logic [11:0] mag_speed;
  logic [15:0] mag_rate;
  logic [16:0] elapsed_sum;
  logic [15:0] elapsed_new;
  logic        settle;
  always_comb begin
    mag_e       = e_q[15] ? 16'(-e_q) : 16'(e_q);
    mag_speed   = speed_q[11] ? 12'(-speed_q) : 12'(speed_q);
    mag_rate    = rate_q[15] ? 16'(-rate_q) : 16'(rate_q);
    elapsed_sum = {1'b0, elapsed_q} + {7'd0, tick_q};
    elapsed_new = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
    settle      = (mag_e < {1'b0, cfg_i.settle_error} &&
                   mag_speed < {1'b0, cfg_i.settle_speed} &&
                   mag_rate < {1'b0, cfg_i.settle_rate}) ||
                  (elapsed_new > cfg_i.timeout_ms);
  end

  assign status_o.pid_tick = (op_q == OP_TICK) && enabled_q && !settle;

  // Shared multiplier
  logic signed [16:0] d_v;
  logic [15:0]        y16;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;
  always_comb begin
    d_v = {e_q[15], e_q} - {prev_q[15], prev_q};
    y16 = mag_q[22:7];
    unique case (cmd_i.mul_sel)
      MUL_E_TICK: begin
        mul_a = {{2{e_q[15]}}, e_q};
        mul_b = {8'd0, tick_q};
      end
      MUL_P_E: begin
        mul_a = {2'b00, cfg_i.gain_p};
        mul_b = {{2{e_q[15]}}, e_q};
      end
      MUL_D_D: begin
        mul_a = {2'b00, cfg_i.gain_d};
        mul_b = {d_v[16], d_v};
      end
      MUL_I_INT: begin
        mul_a = {2'b00, cfg_i.gain_i};
        mul_b = {{4{integ_q[13]}}, integ_q};
      end
      MUL_RECIP: begin
        mul_a = {2'b00, y16};
        mul_b = RECIP5;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // Integral update with clear on overflow
  logic signed [26:0] integ_sum;
  logic [26:0]        integ_mag;
  always_comb begin
    integ_sum = {{13{integral_q[13]}}, integral_q} + prod_q[26:0];
    integ_mag = integ_sum[26] ? 27'(-integ_sum) : 27'(integ_sum);
  end

  // Drive from rounded quotient
  logic [13:0]        q14;
  logic signed [14:0] mag_drive, drive_v;
  always_comb begin
    q14       = prod_q[31:18];
    mag_drive = sat_q ? DRIVE_LIMIT : $signed({1'b0, q14});
    drive_v   = neg_q ? -mag_drive : mag_drive;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      elapsed_q  <= 16'd0;
      integral_q <= 14'sd0;
      prev_q     <= 16'sd0;
    end else begin
      if (cmd_i.eval) begin
        if (op_q == OP_START) begin
          elapsed_q <= 16'd0;
          enabled_q <= 1'b1;
        end else if (enabled_q) begin
          elapsed_q <= elapsed_new;
          if (settle) begin
            enabled_q <= 1'b0;
          end
        end
      end
      if (cmd_i.finish) begin
        integral_q <= integ_q;
        prev_q     <= e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q      <= operation_i;
      heading_q <= heading_i;
      tick_q    <= tick_ms_i;
      speed_q   <= wheel_speed_i;
      rate_q    <= turn_rate_i;
    end
    if (cmd_i.load_err) begin
      e_q <= wrap_v[15:0];
    end
    if (cmd_i.eval) begin
      res_drive_q   <= 15'sd0;
      res_sat_q     <= 1'b0;
      res_settled_q <= (op_q == OP_TICK) && enabled_q && settle;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p[33:0];
    end
    if (cmd_i.integ_ld) begin
      integ_q <= (integ_mag > INTEGRAL_LIMIT) ? 14'sd0 : integ_sum[13:0];
    end
    if (cmd_i.acc_load) begin
      acc_q <= prod_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end else if (cmd_i.acc_add_gated && (e_q <= INTEGRAL_GATE)) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.tri_ld) begin
      n_q <= {acc_q[33], acc_q} + {acc_q, 1'b0};
    end
    if (cmd_i.mag_ld) begin
      neg_q <= n_q[34];
      mag_q <= n_q[34] ? (~n_q + ROUND_BIAS_NEG) : (n_q + ROUND_BIAS);
    end
    if (cmd_i.sat_ld) begin
      sat_q <= (mag_q[34:7] >= SAT_LEVEL);
    end
    if (cmd_i.finish) begin
      res_drive_q <= drive_v;
      res_sat_q   <= sat_q;
    end
    if (cmd_i.out_load) begin
      out_left_q    <= res_drive_q;
      out_right_q   <= -res_drive_q;
      out_err_q     <= e_q;
      out_settled_q <= res_settled_q;
      out_running_q <= enabled_q;
      out_sat_q     <= res_sat_q;
    end
  end

  assign result_o = {7'd0, out_sat_q, out_running_q, out_settled_q,
                     out_err_q, out_right_q, out_left_q};

endmodule

FILE: src/heading_pid_with_settle.sv
// ----------------------------------------------------------------------------
// heading_pid_with_settle
// Heading PID controller with angle wrap, settling test and drive clipping.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel; s_axis_tuser carries the
//   operation (start or control tick). Each item yields exactly one result on
//   the m_axis channel: left and right drive in mV, the wrapped heading error
//   and the settled, running and saturated flags.
//   Gains, target and settling thresholds are written through the cfg port,
//   one register per cycle. The user must write them only while the block is
//   idle; the block itself does not enforce this. A start item, a tick while
//   stopped or a settling tick skips the PID passes; a full PID tick runs
//   the five passes through the one shared 18x18 multiplier plus the scaling
//   and rounding steps. The block works on one item at a time, so a new item
//   is taken only after the last result has gone into the output register.
//   A result waits in the output register while the receiver stalls; the
//   next item is still taken and processed, and then holds until that
//   register is free.
//   Reset clears the loop (disabled, zero integral, previous error and
//   elapsed time) and loads the register defaults.
// ----------------------------------------------------------------------------
module heading_pid_with_settle (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // heading[15:0], tick_ms[25:16], wheel_speed[37:26], turn_rate[53:38]
  input  logic [55:0] s_axis_tdata,
  // operation[0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // left_drive_mv[14:0], right_drive_mv[29:15], wrapped_error[45:30],
  // settled[46], running[47], saturated[48]
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import hps_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  hps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  hps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hps_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .operation_i   (s_axis_tuser[0]),
    .heading_i     (s_axis_tdata[15:0]),
    .tick_ms_i     (s_axis_tdata[25:16]),
    .wheel_speed_i (s_axis_tdata[37:26]),
    .turn_rate_i   (s_axis_tdata[53:38]),
    .result_o      (m_axis_tdata)
  );

endmodule

FILE: src/hps_checker.sv
// ----------------------------------------------------------------------------
// hps_checker
// Port-level checks on the heading PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "heading_pid_with_settle_macros.svh"

module hps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  logic               out_stall;
  logic               in_take;
  logic signed [14:0] left_mv;
  logic signed [14:0] right_mv;
  logic               settled_seen;
  logic               clip_seen;
  logic               stopped;
  logic               at_limit;

  assign out_stall    = m_axis_tvalid && !m_axis_tready;
  assign in_take      = s_axis_tvalid && s_axis_tready;
  assign left_mv      = m_axis_tdata[14:0];
  assign right_mv     = m_axis_tdata[29:15];
  assign settled_seen = m_axis_tvalid && m_axis_tdata[46];
  assign clip_seen    = m_axis_tvalid && m_axis_tdata[48];
  assign stopped      = !m_axis_tdata[47] && (left_mv == 15'sd0);
  assign at_limit     = (left_mv == 15'sd12000) || (left_mv == -15'sd12000);

  `HPS_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "result moved")

  `HPS_ASSERT_NXT(a_one_item, in_take, !s_axis_tready, "item taken while busy")

  `HPS_ASSERT_IMP(a_mirror, m_axis_tvalid, right_mv == -left_mv, "right drive is not negated left")

  `HPS_ASSERT_IMP(a_settled, settled_seen, stopped, "settled item still drives or runs")

  `HPS_ASSERT_IMP(a_clip, clip_seen, at_limit, "saturated drive not at limit")

endmodule

bind heading_pid_with_settle hps_checker u_hps_checker (.*);
